### rtl/core/vtsi_pkg.sv
// Package: shared constants, status codes and controller states for the sync interpolator.
`default_nettype none
package vtsi_pkg;
  localparam int RingDepthDefault = 64;
  localparam int StampW = 48;
  localparam int VelW = 32;
  localparam int GapW = 24;
  localparam int Axes = 6;
  localparam int RowW = Axes * VelW;
  localparam logic [GapW-1:0] MaxGapReset = 24'd200000;

  typedef enum logic [2:0] {
    ST_SYNCED     = 3'd0,
    ST_TOO_FEW    = 3'd1,
    ST_BEFORE     = 3'd2,
    ST_AFTER      = 3'd3,
    ST_GAP_BEFORE = 3'd4,
    ST_GAP_AFTER  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DIV,
    S_OUT
  } ctl_state_t;
endpackage
`default_nettype wire

### rtl/core/vtsi_in_if.sv
// Interface: input request channel (sample push or sync request).
`default_nettype none
interface vtsi_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [47:0] stamp;
  logic signed [31:0] lin_x;
  logic signed [31:0] lin_y;
  logic signed [31:0] lin_z;
  logic signed [31:0] ang_x;
  logic signed [31:0] ang_y;
  logic signed [31:0] ang_z;

  modport source (output valid, kind, stamp, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z,
                  input ready);
  modport sink (input valid, kind, stamp, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z,
                output ready);
endinterface
`default_nettype wire

### rtl/core/vtsi_out_if.sv
// Interface: synced result channel.
`default_nettype none
interface vtsi_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [47:0] out_stamp;
  logic signed [31:0] out_lin_x;
  logic signed [31:0] out_lin_y;
  logic signed [31:0] out_lin_z;
  logic signed [31:0] out_ang_x;
  logic signed [31:0] out_ang_y;
  logic signed [31:0] out_ang_z;

  modport source (output valid, status, out_stamp, out_lin_x, out_lin_y, out_lin_z,
                  out_ang_x, out_ang_y, out_ang_z, input ready);
  modport sink (input valid, status, out_stamp, out_lin_x, out_lin_y, out_lin_z,
                out_ang_x, out_ang_y, out_ang_z, output ready);
endinterface
`default_nettype wire

### rtl/core/vtsi_lane.sv
// Lane: one axis, front + (back - front) * num / den, one magnitude bit per cycle.
`default_nettype none
module vtsi_lane (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [vtsi_pkg::VelW-1:0]   front,
  input  wire logic signed [vtsi_pkg::VelW-1:0]   back,
  input  wire logic [vtsi_pkg::GapW-1:0]     num,
  input  wire logic [vtsi_pkg::StampW-1:0]   den,
  output logic                               done,
  output logic signed [vtsi_pkg::VelW-1:0]   result
);
  localparam int MagW = vtsi_pkg::VelW + 1;
  localparam int RemW = vtsi_pkg::StampW;
  localparam int TW = RemW + 2;
  localparam int CntW = $clog2(MagW + 1);

  logic [MagW-1:0] mag;
  logic [MagW-1:0] quo;
  logic [RemW-1:0] rem;
  logic [RemW-1:0] den_q;
  logic [vtsi_pkg::GapW-1:0] num_q;
  logic signed [vtsi_pkg::VelW-1:0] base;
  logic neg;
  logic busy;
  logic [CntW-1:0] cnt;

  logic signed [MagW-1:0] diff;
  logic [TW-1:0] t;
  logic [TW-1:0] den1;
  logic [TW-1:0] den2;
  logic [MagW-1:0] sum;

  always_comb begin
    diff = MagW'(back) - MagW'(front);
    t = {1'b0, rem, 1'b0} + (mag[MagW-1] ? TW'(num_q) : '0);
    den1 = TW'(den_q);
    den2 = {1'b0, den_q, 1'b0};
    sum = neg ? (MagW'(base) - quo) : (MagW'(base) + quo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(MagW);
        neg <= diff[MagW-1];
        mag <= diff[MagW-1] ? (-diff) : diff;
        base <= front;
        num_q <= num;
        den_q <= den;
        rem <= '0;
        quo <= '0;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          result <= sum[vtsi_pkg::VelW-1:0];
        end else begin
          cnt <= cnt - 1'b1;
          mag <= {mag[MagW-2:0], 1'b0};
          if (t >= den2) begin
            rem <= RemW'(t - den2);
            quo <= {quo[MagW-2:0], 1'b0} + MagW'(2);
          end else if (t >= den1) begin
            rem <= RemW'(t - den1);
            quo <= {quo[MagW-2:0], 1'b1};
          end else begin
            rem <= RemW'(t);
            quo <= {quo[MagW-2:0], 1'b0};
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/vtsi_ring.sv
// Ring storage: sample times and velocity rows, one write port, two registered reads.
`default_nettype none
module vtsi_ring #(
  parameter int RING_DEPTH = vtsi_pkg::RingDepthDefault
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [$clog2(RING_DEPTH)-1:0]        wr_addr,
  input  wire logic [vtsi_pkg::StampW-1:0]          wr_time,
  input  wire logic [vtsi_pkg::RowW-1:0]            wr_row,
  input  wire logic [$clog2(RING_DEPTH)-1:0]        rd_addr_a,
  input  wire logic [$clog2(RING_DEPTH)-1:0]        rd_addr_b,
  output logic [vtsi_pkg::StampW-1:0]               time_a,
  output logic [vtsi_pkg::StampW-1:0]               time_b,
  output logic [vtsi_pkg::RowW-1:0]                 row_a,
  output logic [vtsi_pkg::RowW-1:0]                 row_b
);
  logic [vtsi_pkg::StampW-1:0] times_mem [RING_DEPTH];
  logic [vtsi_pkg::RowW-1:0]   vel_mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      times_mem[wr_addr] <= wr_time;
      vel_mem[wr_addr] <= wr_row;
    end
    time_a <= times_mem[rd_addr_a];
    time_b <= times_mem[rd_addr_b];
    row_a <= vel_mem[rd_addr_a];
    row_b <= vel_mem[rd_addr_b];
  end
endmodule
`default_nettype wire

### rtl/core/velocity_time_sync_interpolator.sv
// Top level: timestamped velocity ring with sync requests answered by six interpolation lanes.
//   channel  | dir | handshake   | payload
//   in_req   | in  | valid/ready | kind, stamp, six Q16.16 velocities
//   out_res  | out | valid/ready | status, out_stamp, six Q16.16 velocities
//   max_gap  | in  | write en    | 24-bit gap limit, us
// A push is written to the ring when it is accepted. A request steps through read and check,
// again for each dropped sample, then through divide while the lanes interpolate, then output.
// rst is synchronous; ring contents are not cleared, the fill count guards reads.
// One request at a time; a finished result waits in the output register while
// new requests are accepted.
`default_nettype none
module velocity_time_sync_interpolator #(
  parameter int RING_DEPTH = vtsi_pkg::RingDepthDefault
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         max_gap_wr_en,
  input  wire logic [vtsi_pkg::GapW-1:0]    max_gap_wr_data,
  vtsi_in_if.sink                           in_req,
  vtsi_out_if.source                        out_res
);
  localparam int IW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int SW = vtsi_pkg::StampW;
  localparam int VW = vtsi_pkg::VelW;
  localparam int RW = vtsi_pkg::RowW;

  vtsi_pkg::ctl_state_t state, state_next;
  logic [IW-1:0] oldest, oldest_next;
  logic [CW-1:0] count, count_next;
  logic [vtsi_pkg::GapW-1:0] max_gap;
  logic [SW-1:0] last_stamp;
  logic [SW-1:0] req_stamp;
  vtsi_pkg::status_t res_status, res_status_next;
  logic [RW-1:0] res_row, res_row_next;
  logic out_valid;
  logic load_out;

  logic push, request;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] oldest_inc;
  logic [CW:0] slot_sum;
  logic [SW-1:0] time_a, time_b;
  logic [RW-1:0] row_a, row_b;
  logic [SW-1:0] diff_a, diff_b;
  logic lane_start;
  logic [vtsi_pkg::Axes-1:0] lane_done;
  logic [RW-1:0] lane_row;

  assign in_req.ready = (state == vtsi_pkg::S_IDLE);
  assign push = in_req.valid && in_req.ready && !in_req.kind;
  assign request = in_req.valid && in_req.ready && in_req.kind;

  always_comb begin
    oldest_inc = (oldest == IW'(RING_DEPTH - 1)) ? '0 : oldest + 1'b1;
    slot_sum = (CW+1)'(oldest) + (CW+1)'(count);
    if (count == CW'(RING_DEPTH)) begin
      wr_addr = oldest;
    end else if (slot_sum >= (CW+1)'(RING_DEPTH)) begin
      wr_addr = IW'(slot_sum - (CW+1)'(RING_DEPTH));
    end else begin
      wr_addr = slot_sum[IW-1:0];
    end
    diff_a = req_stamp - time_a;
    diff_b = time_b - req_stamp;
  end

  vtsi_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk       (clk),
    .wr_en     (push),
    .wr_addr   (wr_addr),
    .wr_time   (in_req.stamp),
    .wr_row    ({in_req.ang_z, in_req.ang_y, in_req.ang_x,
                 in_req.lin_z, in_req.lin_y, in_req.lin_x}),
    .rd_addr_a (oldest),
    .rd_addr_b (oldest_inc),
    .time_a    (time_a),
    .time_b    (time_b),
    .row_a     (row_a),
    .row_b     (row_b)
  );

  for (genvar i = 0; i < vtsi_pkg::Axes; i++) begin : g_lane
    vtsi_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .start  (lane_start),
      .front  (row_a[VW*i +: VW]),
      .back   (row_b[VW*i +: VW]),
      .num    (diff_a[vtsi_pkg::GapW-1:0]),
      .den    (time_b - time_a),
      .done   (lane_done[i]),
      .result (lane_row[VW*i +: VW])
    );
  end

  always_comb begin
    state_next = state;
    oldest_next = oldest;
    count_next = count;
    res_status_next = res_status;
    res_row_next = res_row;
    lane_start = 1'b0;
    load_out = 1'b0;
    case (state)
      vtsi_pkg::S_IDLE: begin
        if (push) begin
          if (count == CW'(RING_DEPTH)) begin
            oldest_next = oldest_inc;
          end else begin
            count_next = count + 1'b1;
          end
        end
        if (request) begin
          state_next = vtsi_pkg::S_READ;
        end
      end
      vtsi_pkg::S_READ: begin
        state_next = vtsi_pkg::S_CHECK;
      end
      vtsi_pkg::S_CHECK: begin
        state_next = vtsi_pkg::S_OUT;
        res_row_next = '0;
        if (count < CW'(2)) begin
          res_status_next = vtsi_pkg::ST_TOO_FEW;
        end else if (time_a > req_stamp) begin
          res_status_next = vtsi_pkg::ST_BEFORE;
        end else if (last_stamp < req_stamp) begin
          res_status_next = vtsi_pkg::ST_AFTER;
        end else if (time_b < req_stamp) begin
          oldest_next = oldest_inc;
          count_next = count - 1'b1;
          state_next = vtsi_pkg::S_READ;
        end else if (diff_a > SW'(max_gap)) begin
          oldest_next = oldest_inc;
          count_next = count - 1'b1;
          res_status_next = vtsi_pkg::ST_GAP_BEFORE;
        end else if (diff_b > SW'(max_gap)) begin
          res_status_next = vtsi_pkg::ST_GAP_AFTER;
        end else if (time_b == time_a) begin
          res_status_next = vtsi_pkg::ST_SYNCED;
          res_row_next = row_a;
        end else begin
          res_status_next = vtsi_pkg::ST_SYNCED;
          lane_start = 1'b1;
          state_next = vtsi_pkg::S_DIV;
        end
      end
      vtsi_pkg::S_DIV: begin
        if (&lane_done) begin
          res_row_next = lane_row;
          state_next = vtsi_pkg::S_OUT;
        end
      end
      vtsi_pkg::S_OUT: begin
        if (!out_valid || out_res.ready) begin
          load_out = 1'b1;
          state_next = vtsi_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = vtsi_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vtsi_pkg::S_IDLE;
      oldest <= '0;
      count <= '0;
      max_gap <= vtsi_pkg::MaxGapReset;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      oldest <= oldest_next;
      count <= count_next;
      if (max_gap_wr_en) begin
        max_gap <= max_gap_wr_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_row <= res_row_next;
    if (push) begin
      last_stamp <= in_req.stamp;
    end
    if (request) begin
      req_stamp <= in_req.stamp;
    end
    if (load_out) begin
      out_res.status <= res_status;
      out_res.out_stamp <= req_stamp;
      out_res.out_lin_x <= res_row[VW*0 +: VW];
      out_res.out_lin_y <= res_row[VW*1 +: VW];
      out_res.out_lin_z <= res_row[VW*2 +: VW];
      out_res.out_ang_x <= res_row[VW*3 +: VW];
      out_res.out_ang_y <= res_row[VW*4 +: VW];
      out_res.out_ang_z <= res_row[VW*5 +: VW];
    end
  end

  assign out_res.valid = out_valid;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(RING_DEPTH)) else $error("fill count above ring depth");
  a_lane_done_in_div: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] |-> state == vtsi_pkg::S_DIV) else $error("lane finished outside divide");
  a_too_few: assert property (@(posedge clk) disable iff (rst)
    (state == vtsi_pkg::S_CHECK && count < CW'(2)) |=>
      (state == vtsi_pkg::S_OUT && res_status == vtsi_pkg::ST_TOO_FEW))
    else $error("too-few status not raised");
  a_div_holds_ring: assert property (@(posedge clk) disable iff (rst)
    state == vtsi_pkg::S_DIV |=> $stable(count) && $stable(oldest))
    else $error("ring moved while dividing");
endmodule
`default_nettype wire
